/* design/gbdp_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and control structs of the gaussian blur derivative products unit
// used by gbdp_ctrl, gbdp_datapath and the top level; depends on nothing
package gbdp_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MIN_WIDTH     = 7;

	// field and register widths
	localparam int PIX_W     = 8;
	localparam int WEIGHT_W  = 16;
	localparam int IMG_W     = 11;
	localparam int SMOOTH_W  = 16;
	localparam int ROW_W     = 16;
	localparam int SIDE_W    = 10;
	localparam int MC_W      = 24;
	localparam int ME_W      = 26;
	localparam int SUM_W     = 28;
	localparam int FRAC_SH   = 8;
	localparam int Q_W       = SUM_W - FRAC_SH;
	localparam int DERIV_W   = 19;
	localparam int PROD_W    = 2 * DERIV_W;
	localparam int GXX_W     = 34;
	localparam int GXY_W     = 35;
	localparam int COL_OUT_W = 10;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [WEIGHT_W-1:0] WC_RST      = 16'd16384;
	localparam logic [WEIGHT_W-1:0] WE_RST      = 16'd8192;
	localparam logic [WEIGHT_W-1:0] WK_RST      = 16'd4096;
	localparam logic [IMG_W-1:0]    IMG_W_RST   = 11'd640;
	localparam logic [ROW_W-1:0]    ROW_SAT     = 16'hFFFF;
	localparam logic [SUM_W-1:0]    ROUND_BIAS  = 28'd128;
	localparam logic [SMOOTH_W-1:0] SMOOTH_MAX  = 16'hFFFF;

	typedef logic [PIX_W-1:0]           pixel_t;
	typedef logic [SMOOTH_W-1:0]        smooth_t;
	typedef logic signed [DERIV_W-1:0]  deriv_t;

	typedef enum logic [1:0] {
		REG_WEIGHT_CENTER,
		REG_WEIGHT_EDGE,
		REG_WEIGHT_CORNER,
		REG_IMAGE_WIDTH
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WINDOW,
		ST_MULT,
		ST_SUM,
		ST_DIFF,
		ST_PROD,
		ST_EDGE_RD,
		ST_EDGE_A,
		ST_EDGE_B
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_lines;
		logic window;
		logic mult;
		logic sum;
		logic diff;
		logic out_load;
		logic edge_rd;
		logic edge_a;
		logic edge_b;
	} cmd_t;

	typedef struct packed {
		logic gauss_en;
		logic deriv_en;
		logic out_en;
		logic row_end;
		logic out_busy;
	} status_t;

endpackage

/* design/gbdp_ctrl.sv */
`timescale 1ns / 1ps
// sequencer of the gaussian blur derivative products unit: one pixel request at a time
// depends on gbdp_pkg (state_t, cmd_t, status_t)
module gbdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  gbdp_pkg::status_t stat,
	output gbdp_pkg::cmd_t    cmd,
	output logic              pix_stall
);

	gbdp_pkg::state_t state_q;
	gbdp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbdp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbdp_pkg::ST_IDLE: begin
				if (pix_valid) state_d = gbdp_pkg::ST_READ;
			end
			gbdp_pkg::ST_READ: state_d = gbdp_pkg::ST_WINDOW;
			gbdp_pkg::ST_WINDOW: begin
				state_d = stat.gauss_en ? gbdp_pkg::ST_MULT : gbdp_pkg::ST_IDLE;
			end
			gbdp_pkg::ST_MULT: state_d = gbdp_pkg::ST_SUM;
			gbdp_pkg::ST_SUM: begin
				state_d = stat.deriv_en ? gbdp_pkg::ST_DIFF : gbdp_pkg::ST_IDLE;
			end
			gbdp_pkg::ST_DIFF: begin
				if (stat.out_en) state_d = gbdp_pkg::ST_PROD;
				else if (stat.row_end) state_d = gbdp_pkg::ST_EDGE_RD;
				else state_d = gbdp_pkg::ST_IDLE;
			end
			gbdp_pkg::ST_PROD: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					state_d = stat.row_end ? gbdp_pkg::ST_EDGE_RD : gbdp_pkg::ST_IDLE;
				end
			end
			gbdp_pkg::ST_EDGE_RD: state_d = gbdp_pkg::ST_EDGE_A;
			gbdp_pkg::ST_EDGE_A:  state_d = gbdp_pkg::ST_EDGE_B;
			gbdp_pkg::ST_EDGE_B:  state_d = gbdp_pkg::ST_IDLE;
			default: state_d = gbdp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		pix_stall = 1'b1;
		case (state_q)
			gbdp_pkg::ST_IDLE: begin
				pix_stall = 1'b0;
				cmd.load  = pix_valid;
			end
			gbdp_pkg::ST_READ:    cmd.rd_lines = 1'b1;
			gbdp_pkg::ST_WINDOW:  cmd.window   = 1'b1;
			gbdp_pkg::ST_MULT:    cmd.mult     = 1'b1;
			gbdp_pkg::ST_SUM:     cmd.sum      = 1'b1;
			gbdp_pkg::ST_DIFF:    cmd.diff     = 1'b1;
			gbdp_pkg::ST_PROD:    cmd.out_load = !stat.out_busy;
			gbdp_pkg::ST_EDGE_RD: cmd.edge_rd  = 1'b1;
			gbdp_pkg::ST_EDGE_A:  cmd.edge_a   = 1'b1;
			gbdp_pkg::ST_EDGE_B:  cmd.edge_b   = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

/* design/gbdp_datapath.sv */
`timescale 1ns / 1ps
// datapath: position counters, pixel and smoothed line memories, 3x3 gaussian,
// second differences and the result register; depends on gbdp_pkg
module gbdp_datapath #(
	parameter int MAX_WIDTH = gbdp_pkg::MAX_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  gbdp_pkg::cmd_t                          cmd,
	output gbdp_pkg::status_t                       stat,
	input  logic [gbdp_pkg::PIX_W-1:0]              pixel,
	input  logic                                    frame_start,
	input  logic [gbdp_pkg::WEIGHT_W-1:0]           weight_center,
	input  logic [gbdp_pkg::WEIGHT_W-1:0]           weight_edge,
	input  logic [gbdp_pkg::WEIGHT_W-1:0]           weight_corner,
	input  logic [gbdp_pkg::IMG_W-1:0]              image_width,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output logic [gbdp_pkg::GXX_W-1:0]              grad_xx,
	output logic [gbdp_pkg::GXX_W-1:0]              grad_yy,
	output logic signed [gbdp_pkg::GXY_W-1:0]       grad_xy,
	output logic [gbdp_pkg::COL_OUT_W-1:0]          out_column,
	output logic                                    out_row_end
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int FW     = $clog2(MAX_WIDTH + 1);
	localparam int CMPW   = (FW > gbdp_pkg::IMG_W) ? FW : gbdp_pkg::IMG_W;
	localparam int FW_RST = (int'(gbdp_pkg::IMG_W_RST) > MAX_WIDTH) ?
		MAX_WIDTH : int'(gbdp_pkg::IMG_W_RST);

	// position of the next pixel and of the pixel in work
	logic [AW-1:0]             col_q;
	logic [gbdp_pkg::ROW_W-1:0] row_q;
	logic [AW-1:0]             cur_col_q;
	logic [gbdp_pkg::ROW_W-1:0] cur_row_q;
	logic [FW-1:0]             fw_q;
	gbdp_pkg::pixel_t          pix_q;

	logic [AW-1:0]              c_now;
	logic [gbdp_pkg::ROW_W-1:0] r_now;
	logic [CMPW-1:0]            iw_ext;
	logic [FW-1:0]              fw_clamp;
	logic [FW-1:0]              fw_now;
	logic                       wrap;

	always_comb begin
		c_now  = frame_start ? '0 : col_q;
		r_now  = frame_start ? '0 : row_q;
		iw_ext = CMPW'(image_width);
		if (iw_ext < CMPW'(gbdp_pkg::MIN_WIDTH)) fw_clamp = FW'(gbdp_pkg::MIN_WIDTH);
		else if (iw_ext > CMPW'(MAX_WIDTH)) fw_clamp = FW'(MAX_WIDTH);
		else fw_clamp = FW'(iw_ext);
		// width is taken only at the first pixel of a frame
		fw_now = (c_now == '0 && r_now == '0) ? fw_clamp : fw_q;
		wrap   = (FW'(c_now) + FW'(1)) >= fw_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			fw_q      <= FW'(FW_RST);
		end else if (cmd.load) begin
			cur_col_q <= c_now;
			cur_row_q <= r_now;
			fw_q      <= fw_now;
			if (wrap) begin
				col_q <= '0;
				row_q <= (r_now == gbdp_pkg::ROW_SAT) ? r_now : r_now + 1'b1;
			end else begin
				col_q <= c_now + 1'b1;
				row_q <= r_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) pix_q <= pixel;
	end

	logic row_end;
	assign row_end = stat.gauss_en && (FW'(cur_col_q) == fw_q - FW'(1));

	always_comb begin
		stat.gauss_en = (cur_row_q >= gbdp_pkg::ROW_W'(2)) && (cur_col_q >= AW'(2));
		stat.deriv_en = cur_col_q >= AW'(4);
		stat.out_en   = (cur_row_q >= gbdp_pkg::ROW_W'(4)) && (cur_col_q >= AW'(4));
		stat.row_end  = row_end;
		stat.out_busy = res_valid && res_stall;
	end

	// smoothed-grid addresses: j for the current column, e0/e1 for the last two of a row
	logic [AW-1:0] j_addr;
	logic [AW-1:0] j1_addr;
	logic [AW-1:0] j2_addr;
	logic [AW-1:0] e0_addr;
	logic [AW-1:0] e1_addr;

	assign j_addr  = cur_col_q - AW'(4);
	assign j1_addr = j_addr + AW'(1);
	assign j2_addr = j_addr + AW'(2);
	assign e0_addr = AW'(fw_q - FW'(4));
	assign e1_addr = AW'(fw_q - FW'(3));

	// pixel line memories
	gbdp_pkg::pixel_t pix_line_a [MAX_WIDTH];
	gbdp_pkg::pixel_t pix_line_b [MAX_WIDTH];
	gbdp_pkg::pixel_t pla_rd_q;
	gbdp_pkg::pixel_t plb_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_lines) begin
			pla_rd_q <= pix_line_a[cur_col_q];
			plb_rd_q <= pix_line_b[cur_col_q];
		end
		if (cmd.window) begin
			pix_line_a[cur_col_q] <= plb_rd_q;
			pix_line_b[cur_col_q] <= pix_q;
		end
	end

	// 3x3 window, [row][col], col 2 newest
	gbdp_pkg::pixel_t win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.window) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= pla_rd_q;
			win_q[1][2] <= plb_rd_q;
			win_q[2][2] <= pix_q;
		end
	end

	// gaussian: products, then sum with rounding and saturation
	logic [gbdp_pkg::SIDE_W-1:0] side_sum;
	logic [gbdp_pkg::SIDE_W-1:0] diag_sum;
	logic [gbdp_pkg::MC_W-1:0]   mc_q;
	logic [gbdp_pkg::ME_W-1:0]   me_q;
	logic [gbdp_pkg::ME_W-1:0]   mk_q;

	assign side_sum = gbdp_pkg::SIDE_W'(win_q[0][1]) + gbdp_pkg::SIDE_W'(win_q[1][0])
		+ gbdp_pkg::SIDE_W'(win_q[1][2]) + gbdp_pkg::SIDE_W'(win_q[2][1]);
	assign diag_sum = gbdp_pkg::SIDE_W'(win_q[0][0]) + gbdp_pkg::SIDE_W'(win_q[0][2])
		+ gbdp_pkg::SIDE_W'(win_q[2][0]) + gbdp_pkg::SIDE_W'(win_q[2][2]);

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			mc_q <= gbdp_pkg::MC_W'(weight_center) * gbdp_pkg::MC_W'(win_q[1][1]);
			me_q <= gbdp_pkg::ME_W'(weight_edge) * gbdp_pkg::ME_W'(side_sum);
			mk_q <= gbdp_pkg::ME_W'(weight_corner) * gbdp_pkg::ME_W'(diag_sum);
		end
	end

	logic [gbdp_pkg::SUM_W-1:0] g_sum;
	logic [gbdp_pkg::Q_W-1:0]   g_q;
	gbdp_pkg::smooth_t          g_smooth;

	always_comb begin
		g_sum = gbdp_pkg::SUM_W'(mc_q) + gbdp_pkg::SUM_W'(me_q) + gbdp_pkg::SUM_W'(mk_q)
			+ gbdp_pkg::ROUND_BIAS;
		g_q   = g_sum[gbdp_pkg::SUM_W-1:gbdp_pkg::FRAC_SH];
		g_smooth = (|g_q[gbdp_pkg::Q_W-1:gbdp_pkg::SMOOTH_W]) ?
			gbdp_pkg::SMOOTH_MAX : g_q[gbdp_pkg::SMOOTH_W-1:0];
	end

	// last three smoothed values of the row, index 2 newest
	gbdp_pkg::smooth_t srw_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srw_q[0] <= '0;
			srw_q[1] <= '0;
			srw_q[2] <= '0;
		end else if (cmd.sum) begin
			srw_q[0] <= srw_q[1];
			srw_q[1] <= srw_q[2];
			srw_q[2] <= g_smooth;
		end
	end

	// smoothed line memories: a holds the older row, b the newer
	gbdp_pkg::smooth_t smooth_line_a [MAX_WIDTH];
	gbdp_pkg::smooth_t smooth_line_b [MAX_WIDTH];
	gbdp_pkg::smooth_t sa_rd0_q;
	gbdp_pkg::smooth_t sa_rd1_q;
	gbdp_pkg::smooth_t sb_rd_q;
	gbdp_pkg::smooth_t sa_j_q;

	logic              sl_we;
	logic [AW-1:0]     sl_waddr;
	gbdp_pkg::smooth_t sb_wdata;

	always_comb begin
		sl_we = cmd.diff || cmd.edge_a || cmd.edge_b;
		if (cmd.diff) begin
			sl_waddr = j_addr;
			sb_wdata = srw_q[0];
		end else if (cmd.edge_a) begin
			sl_waddr = e0_addr;
			sb_wdata = srw_q[1];
		end else begin
			sl_waddr = e1_addr;
			sb_wdata = srw_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_lines) begin
			sa_rd0_q <= smooth_line_a[j_addr];
			sa_rd1_q <= smooth_line_a[j1_addr];
		end else if (cmd.window) begin
			sa_rd0_q <= smooth_line_a[j2_addr];
		end
		if (sl_we) smooth_line_a[sl_waddr] <= sb_rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_lines) sb_rd_q <= smooth_line_b[j_addr];
		else if (cmd.edge_rd) sb_rd_q <= smooth_line_b[e0_addr];
		else if (cmd.edge_a) sb_rd_q <= smooth_line_b[e1_addr];
		if (sl_we) smooth_line_b[sl_waddr] <= sb_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.window) sa_j_q <= sa_rd0_q;
	end

	// second differences, exact in 19 bits
	gbdp_pkg::deriv_t ix_q;
	gbdp_pkg::deriv_t iy_q;
	gbdp_pkg::deriv_t ext_aj;
	gbdp_pkg::deriv_t ext_aj1;
	gbdp_pkg::deriv_t ext_aj2;
	gbdp_pkg::deriv_t ext_bj;
	gbdp_pkg::deriv_t ext_cur;

	always_comb begin
		ext_aj  = gbdp_pkg::deriv_t'({3'b000, sa_j_q});
		ext_aj1 = gbdp_pkg::deriv_t'({3'b000, sa_rd1_q});
		ext_aj2 = gbdp_pkg::deriv_t'({3'b000, sa_rd0_q});
		ext_bj  = gbdp_pkg::deriv_t'({3'b000, sb_rd_q});
		ext_cur = gbdp_pkg::deriv_t'({3'b000, srw_q[0]});
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			ix_q <= ext_aj - (ext_aj1 <<< 1) + ext_aj2;
			iy_q <= ext_aj - (ext_bj <<< 1) + ext_cur;
		end
	end

	// products into the result register
	logic signed [gbdp_pkg::PROD_W-1:0] p_xx;
	logic signed [gbdp_pkg::PROD_W-1:0] p_yy;
	logic signed [gbdp_pkg::PROD_W-1:0] p_xy;

	assign p_xx = ix_q * ix_q;
	assign p_yy = iy_q * iy_q;
	assign p_xy = ix_q * iy_q;

	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			grad_xx     <= p_xx[gbdp_pkg::GXX_W-1:0];
			grad_yy     <= p_yy[gbdp_pkg::GXX_W-1:0];
			grad_xy     <= p_xy[gbdp_pkg::GXY_W-1:0];
			out_column  <= gbdp_pkg::COL_OUT_W'(j_addr);
			out_row_end <= row_end;
		end
	end

	assign res_valid = res_valid_q;

endmodule

/* design/gaussian_blur_derivative_products_unit.sv */
`timescale 1ns / 1ps
// top level: configuration registers, sequencer and datapath of the blur derivative products unit
// depends on gbdp_pkg, gbdp_ctrl and gbdp_datapath
//
// Pixels enter in raster order on the pix channel (pixel, frame_start; pix_valid/pix_stall);
// frame_start marks row 0, column 0 of a new frame. Results leave on the res channel
// (grad_xx, grad_yy, grad_xy, out_column, out_row_end; res_valid/res_stall), one for each
// position of the valid gradient grid, starting at input row 4 and column 4.
// Weights and image_width sit on the APB port; image_width is latched at each frame start.
// One pixel is in work at a time. Every pixel goes through the read and window steps;
// from row 2 and column 2 the 3x3 gaussian multiply and sum follow, from column 4 on the
// smoothed line update, and from row 4 and column 4 the result load. At the end of every
// smoothed row an edge read and the edge_a and edge_b steps make the two trailing line
// writes. These steps come from the sequencer and the ports of the line memories.
// The result register parts both channels: the next pixel is taken while a result waits.
// A stalled receiver holds the result; the unit then waits before loading the next one.
// Reset clears position, window and result valid and restores the register reset values.
module gaussian_blur_derivative_products_unit #(
	parameter int MAX_WIDTH = gbdp_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gbdp_pkg::PADDR_W-1:0]         paddr,
	input  logic [gbdp_pkg::PDATA_W-1:0]         pwdata,
	output logic [gbdp_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 pix_valid,
	output logic                                 pix_stall,
	input  logic [gbdp_pkg::PIX_W-1:0]           pixel,
	input  logic                                 frame_start,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [gbdp_pkg::GXX_W-1:0]           grad_xx,
	output logic [gbdp_pkg::GXX_W-1:0]           grad_yy,
	output logic signed [gbdp_pkg::GXY_W-1:0]    grad_xy,
	output logic [gbdp_pkg::COL_OUT_W-1:0]       out_column,
	output logic                                 out_row_end
);

	logic [gbdp_pkg::WEIGHT_W-1:0] weight_center_q;
	logic [gbdp_pkg::WEIGHT_W-1:0] weight_edge_q;
	logic [gbdp_pkg::WEIGHT_W-1:0] weight_corner_q;
	logic [gbdp_pkg::IMG_W-1:0]    image_width_q;
	gbdp_pkg::reg_idx_t            reg_idx;
	logic                          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = gbdp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_center_q <= gbdp_pkg::WC_RST;
			weight_edge_q   <= gbdp_pkg::WE_RST;
			weight_corner_q <= gbdp_pkg::WK_RST;
			image_width_q   <= gbdp_pkg::IMG_W_RST;
		end else if (wr_en) begin
			case (reg_idx)
				gbdp_pkg::REG_WEIGHT_CENTER: weight_center_q <= pwdata[gbdp_pkg::WEIGHT_W-1:0];
				gbdp_pkg::REG_WEIGHT_EDGE:   weight_edge_q   <= pwdata[gbdp_pkg::WEIGHT_W-1:0];
				gbdp_pkg::REG_WEIGHT_CORNER: weight_corner_q <= pwdata[gbdp_pkg::WEIGHT_W-1:0];
				gbdp_pkg::REG_IMAGE_WIDTH:   image_width_q   <= pwdata[gbdp_pkg::IMG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gbdp_pkg::REG_WEIGHT_CENTER: prdata = gbdp_pkg::PDATA_W'(weight_center_q);
			gbdp_pkg::REG_WEIGHT_EDGE:   prdata = gbdp_pkg::PDATA_W'(weight_edge_q);
			gbdp_pkg::REG_WEIGHT_CORNER: prdata = gbdp_pkg::PDATA_W'(weight_corner_q);
			gbdp_pkg::REG_IMAGE_WIDTH:   prdata = gbdp_pkg::PDATA_W'(image_width_q);
			default: prdata = '0;
		endcase
	end

	gbdp_pkg::cmd_t    cmd;
	gbdp_pkg::status_t stat;

	gbdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.stat      (stat),
		.cmd       (cmd),
		.pix_stall (pix_stall)
	);

	gbdp_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.pixel         (pixel),
		.frame_start   (frame_start),
		.weight_center (weight_center_q),
		.weight_edge   (weight_edge_q),
		.weight_corner (weight_corner_q),
		.image_width   (image_width_q),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.grad_xx       (grad_xx),
		.grad_yy       (grad_yy),
		.grad_xy       (grad_xy),
		.out_column    (out_column),
		.out_row_end   (out_row_end)
	);

	// one pixel in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("pixel taken while another is in work");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(res_valid && res_stall))
		else $error("result register loaded while the receiver stalls");

	// trailing line writes only at the end of a smoothed row
	a_edge_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edge_rd |-> stat.row_end && stat.gauss_en)
		else $error("row end line update outside a row end");

endmodule
